// File: rtl/bso_pkg.sv
// shared types for the box/sphere overlap test pipeline
`default_nettype none

package bso_pkg;

	// pair kind carried with every beat
	typedef enum logic [1:0] {
		CMD_BOX_BOX    = 2'd0,
		CMD_SPHERE     = 2'd1,
		CMD_BOX_SPHERE = 2'd2
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/bso_prep.sv
// stages 1 and 2: absolute offsets, box-box compare, multiplier operand select
`default_nettype none

module bso_prep import bso_pkg::*; #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic [COORD_BITS-2:0]        first_ext_x,
	input  logic [COORD_BITS-2:0]        first_ext_y,
	input  logic [COORD_BITS-2:0]        first_ext_z,
	input  logic [COORD_BITS-2:0]        second_ext_x,
	input  logic [COORD_BITS-2:0]        second_ext_y,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         sphere_test,
	output logic                         bb_hit,
	output logic [COORD_BITS:0]          mag_x,
	output logic [COORD_BITS:0]          mag_y,
	output logic [COORD_BITS:0]          mag_z,
	output logic [COORD_BITS:0]          radius
);

	localparam int MW = COORD_BITS + 1;

	function automatic logic [MW-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
			input logic signed [COORD_BITS-1:0] b);
		logic signed [MW-1:0] d;
		d = MW'(a) - MW'(b);
		return d[MW-1] ? $unsigned(-d) : $unsigned(d);
	endfunction

	// stage 1 registers
	logic                  v_s1;
	cmd_t                  cmd_s1;
	logic [MW-1:0]         ax_s1, ay_s1, az_s1;
	logic [COORD_BITS-2:0] fex_s1, fey_s1, fez_s1, sex_s1, sey_s1;

	// stage 2 registers
	logic                  v_s2;
	logic                  sph_s2, bb_s2;
	logic [MW-1:0]         mx_s2, my_s2, mz_s2, r_s2;

	logic adv1, adv2;

	assign adv2     = !v_s2 || !out_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			cmd_s1 <= cmd_t'(command);
			ax_s1  <= abs_diff(first_x, second_x);
			ay_s1  <= abs_diff(first_y, second_y);
			az_s1  <= abs_diff(first_z, second_z);
			fex_s1 <= first_ext_x;
			fey_s1 <= first_ext_y;
			fez_s1 <= first_ext_z;
			sex_s1 <= second_ext_x;
			sey_s1 <= second_ext_y;
		end
	end

	// stage 2 logic
	logic [COORD_BITS-1:0] sum_x, sum_y;
	logic [MW-1:0]         ex, ey, ez;
	logic                  sph_d, bb_d;
	logic [MW-1:0]         mx_d, my_d, mz_d, r_d;

	always_comb begin
		sum_x = COORD_BITS'(fex_s1) + COORD_BITS'(sex_s1);
		sum_y = COORD_BITS'(fey_s1) + COORD_BITS'(sey_s1);
		// distance past the box face, zero inside
		ex = (ax_s1 > MW'(fex_s1)) ? ax_s1 - MW'(fex_s1) : '0;
		ey = (ay_s1 > MW'(fey_s1)) ? ay_s1 - MW'(fey_s1) : '0;
		ez = (az_s1 > MW'(fez_s1)) ? az_s1 - MW'(fez_s1) : '0;
		sph_d = 1'b0;
		bb_d  = 1'b0;
		mx_d  = '0;
		my_d  = '0;
		mz_d  = '0;
		r_d   = '0;
		unique case (cmd_s1)
			CMD_BOX_BOX: begin
				bb_d = (ax_s1 <= MW'(sum_x)) && (ay_s1 <= MW'(sum_y));
			end
			CMD_SPHERE: begin
				sph_d = 1'b1;
				mx_d  = ax_s1;
				my_d  = ay_s1;
				mz_d  = az_s1;
				r_d   = MW'(sum_x);
			end
			CMD_BOX_SPHERE: begin
				sph_d = 1'b1;
				mx_d  = ex;
				my_d  = ey;
				mz_d  = ez;
				r_d   = MW'(sex_s1);
			end
			default: begin
				sph_d = 1'b0;
				bb_d  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			sph_s2 <= sph_d;
			bb_s2  <= bb_d;
			mx_s2  <= mx_d;
			my_s2  <= my_d;
			mz_s2  <= mz_d;
			r_s2   <= r_d;
		end
	end

	assign out_valid   = v_s2;
	assign sphere_test = sph_s2;
	assign bb_hit      = bb_s2;
	assign mag_x       = mx_s2;
	assign mag_y       = my_s2;
	assign mag_z       = mz_s2;
	assign radius      = r_s2;

endmodule

`default_nettype wire

// File: rtl/bso_square.sv
// stage 3: the four squaring multipliers
`default_nettype none

module bso_square #(
	parameter int COORD_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  sphere_test,
	input  logic                  bb_hit,
	input  logic [COORD_BITS:0]   mag_x,
	input  logic [COORD_BITS:0]   mag_y,
	input  logic [COORD_BITS:0]   mag_z,
	input  logic [COORD_BITS:0]   radius,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  sphere_test_sq,
	output logic                  bb_hit_sq,
	output logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_x,
	output logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_y,
	output logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_z,
	output logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_r
);

	localparam int PROD_W = 2 * COORD_BITS + 2;
	// squares and sums wrap at 64 bits, exact below that
	localparam int ACC_W  = (2 * COORD_BITS + 4 > 64) ? 64 : 2 * COORD_BITS + 4;

	logic              v_s3, sph_s3, bb_s3;
	logic [ACC_W-1:0]  px_s3, py_s3, pz_s3, pr_s3;
	logic [PROD_W-1:0] px, py, pz, pr;
	logic              adv;

	assign adv      = !v_s3 || !out_stall;
	assign in_stall = !adv;

	assign px = PROD_W'(mag_x) * PROD_W'(mag_x);
	assign py = PROD_W'(mag_y) * PROD_W'(mag_y);
	assign pz = PROD_W'(mag_z) * PROD_W'(mag_z);
	assign pr = PROD_W'(radius) * PROD_W'(radius);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			sph_s3 <= sphere_test;
			bb_s3  <= bb_hit;
			px_s3  <= ACC_W'(px);
			py_s3  <= ACC_W'(py);
			pz_s3  <= ACC_W'(pz);
			pr_s3  <= ACC_W'(pr);
		end
	end

	assign out_valid      = v_s3;
	assign sphere_test_sq = sph_s3;
	assign bb_hit_sq      = bb_s3;
	assign sq_x           = px_s3;
	assign sq_y           = py_s3;
	assign sq_z           = pz_s3;
	assign sq_r           = pr_s3;

endmodule

`default_nettype wire

// File: rtl/bso_compare.sv
// stage 4: sum of squares, distance compare or box-box pass-through, result register
`default_nettype none

module bso_compare #(
	parameter int COORD_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic sphere_test,
	input  logic bb_hit,
	input  logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_x,
	input  logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_y,
	input  logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_z,
	input  logic [((2*COORD_BITS+4 > 64) ? 64 : 2*COORD_BITS+4)-1:0] sq_r,
	output logic out_valid,
	input  logic out_stall,
	output logic hit
);

	localparam int ACC_W = (2 * COORD_BITS + 4 > 64) ? 64 : 2 * COORD_BITS + 4;

	logic             v_s4, hit_s4;
	logic [ACC_W-1:0] dist2;
	logic             adv;

	assign adv      = !v_s4 || !out_stall;
	assign in_stall = !adv;
	assign dist2    = sq_x + sq_y + sq_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			hit_s4 <= sphere_test ? (dist2 < sq_r) : bb_hit;
		end
	end

	assign out_valid = v_s4;
	assign hit       = hit_s4;

endmodule

`default_nettype wire

// File: rtl/box_sphere_overlap_test.sv
// top level: pair overlap tester for boxes and spheres
// throughput: one pair per cycle while result_stall is low;
// each of the four stages holds one beat
// and moves whenever the stage after it is free, so a stall only fills bubbles
// the squaring multipliers sit alone in stage 3 and set the clock period
// reset clears every stage valid bit; payload registers are not reset
`default_nettype none

module box_sphere_overlap_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pair_valid,
	output logic                         pair_stall,
	input  logic [1:0]                   command,
	input  logic signed [COORD_BITS-1:0] first_x,
	input  logic signed [COORD_BITS-1:0] first_y,
	input  logic signed [COORD_BITS-1:0] first_z,
	input  logic signed [COORD_BITS-1:0] second_x,
	input  logic signed [COORD_BITS-1:0] second_y,
	input  logic signed [COORD_BITS-1:0] second_z,
	input  logic [COORD_BITS-2:0]        first_ext_x,
	input  logic [COORD_BITS-2:0]        first_ext_y,
	input  logic [COORD_BITS-2:0]        first_ext_z,
	input  logic [COORD_BITS-2:0]        second_ext_x,
	input  logic [COORD_BITS-2:0]        second_ext_y,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         hit
);

	localparam int ACC_W = (2 * COORD_BITS + 4 > 64) ? 64 : 2 * COORD_BITS + 4;

	logic                  prep_valid, prep_stall;
	logic                  prep_sph, prep_bb;
	logic [COORD_BITS:0]   mag_x, mag_y, mag_z, radius;

	logic                  sq_valid, sq_stall;
	logic                  sq_sph, sq_bb;
	logic [ACC_W-1:0]      sq_x, sq_y, sq_z, sq_r;

	bso_prep #(.COORD_BITS(COORD_BITS)) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pair_valid),
		.in_stall     (pair_stall),
		.command      (command),
		.first_x      (first_x),
		.first_y      (first_y),
		.first_z      (first_z),
		.second_x     (second_x),
		.second_y     (second_y),
		.second_z     (second_z),
		.first_ext_x  (first_ext_x),
		.first_ext_y  (first_ext_y),
		.first_ext_z  (first_ext_z),
		.second_ext_x (second_ext_x),
		.second_ext_y (second_ext_y),
		.out_valid    (prep_valid),
		.out_stall    (prep_stall),
		.sphere_test  (prep_sph),
		.bb_hit       (prep_bb),
		.mag_x        (mag_x),
		.mag_y        (mag_y),
		.mag_z        (mag_z),
		.radius       (radius)
	);

	bso_square #(.COORD_BITS(COORD_BITS)) u_square (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (prep_valid),
		.in_stall       (prep_stall),
		.sphere_test    (prep_sph),
		.bb_hit         (prep_bb),
		.mag_x          (mag_x),
		.mag_y          (mag_y),
		.mag_z          (mag_z),
		.radius         (radius),
		.out_valid      (sq_valid),
		.out_stall      (sq_stall),
		.sphere_test_sq (sq_sph),
		.bb_hit_sq      (sq_bb),
		.sq_x           (sq_x),
		.sq_y           (sq_y),
		.sq_z           (sq_z),
		.sq_r           (sq_r)
	);

	bso_compare #(.COORD_BITS(COORD_BITS)) u_compare (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sq_valid),
		.in_stall    (sq_stall),
		.sphere_test (sq_sph),
		.bb_hit      (sq_bb),
		.sq_x        (sq_x),
		.sq_y        (sq_y),
		.sq_z        (sq_z),
		.sq_r        (sq_r),
		.out_valid   (result_valid),
		.out_stall   (result_stall),
		.hit         (hit)
	);

endmodule

`default_nettype wire
